// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle implication failed");

`endif

// ----- rtl/lmss_pkg.sv -----
// constants, codes and structs of the marquee scroll sequencer
// no dependencies
package lmss_pkg;

	// display geometry and frame store limits
	localparam int SCREEN_COLUMNS = 64;
	localparam int SCREEN_ROWS    = 16;
	localparam int FRAME_COUNT    = 8;
	localparam int TEXT_MAX       = 1024;

	// field and state widths
	localparam int OFS_W      = 14;
	localparam int VC_W       = 7;
	localparam int DIV_W      = 9;
	localparam int HOLD_W     = 11;
	localparam int FRAME_W    = 3;
	localparam int RATE_W     = 8;
	localparam int MODE_W     = 3;
	localparam int LEN_W      = $clog2(TEXT_MAX + 1);
	localparam int MODEIN_W   = 8;
	localparam int LENIN_W    = 16;
	localparam int COLCFG_W   = 8;
	localparam int PAUSE_W    = 10;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// working widths for the signed position math
	localparam int CALC_W  = 16;
	localparam int VCALC_W = 8;

	localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'((1 << DIV_W) - 1);
	localparam logic signed [CALC_W-1:0] COLS_S = CALC_W'(SCREEN_COLUMNS);
	localparam logic signed [VCALC_W-1:0] ROWS_S = VCALC_W'(SCREEN_ROWS);
	localparam logic signed [VCALC_W-1:0] ROWS2_S = VCALC_W'(2 * SCREEN_ROWS);

	// item function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// scroll modes
	localparam logic [MODE_W-1:0] MODE_LEFT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RIGHT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UP     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DOWN   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CONT   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FAST_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIDE_COLUMNS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE_TICKS    = 2'd3;

	typedef struct packed {
		logic [COLCFG_W-1:0] fast_threshold;
		logic [COLCFG_W-1:0] hide_columns;
		logic [RATE_W-1:0]   rate_limit;
		logic [PAUSE_W-1:0]  pause_ticks;
	} lmss_cfg_t;

	typedef struct packed {
		logic                func;
		logic [RATE_W-1:0]   frame_rate;
		logic [MODEIN_W-1:0] frame_mode;
		logic [LENIN_W-1:0]  frame_length;
	} lmss_item_t;

	typedef struct packed {
		logic [DIV_W-1:0]        tick_divider;
		logic signed [OFS_W-1:0] offset;
		logic signed [VC_W-1:0]  vcount;
		logic                    hold_flag;
		logic [HOLD_W-1:0]       hold_counter;
		logic [FRAME_W-1:0]      frame_sel;
		logic [RATE_W-1:0]       cur_rate;
		logic [MODE_W-1:0]       cur_mode;
		logic [LEN_W-1:0]        cur_length;
		logic                    pending;
	} lmss_state_t;

endpackage

// ----- rtl/lmss_step.sv -----
// next-state logic of the scroll sequencer: one tick or one frame load
// depends on lmss_pkg
module lmss_step (
	input  lmss_pkg::lmss_cfg_t   cfg,
	input  lmss_pkg::lmss_state_t st,
	input  lmss_pkg::lmss_item_t  item,
	output lmss_pkg::lmss_state_t nxt
);
	import lmss_pkg::*;

	logic signed [CALC_W-1:0]  ofs;
	logic signed [CALC_W-1:0]  end_h;
	logic signed [CALC_W-1:0]  end_v;
	logic signed [CALC_W-1:0]  colstep;
	logic signed [VCALC_W-1:0] vc;
	logic [HOLD_W-1:0]         hc;
	logic                      hold;
	logic                      req;
	logic                      done;
	logic [DIV_W-1:0]          div;
	logic [FRAME_W:0]          sel_inc;
	logic [LEN_W-1:0]          ld_len;
	logic [MODE_W-1:0]         ld_mode;

	always_comb begin
		nxt     = st;
		ofs     = {{(CALC_W-OFS_W){st.offset[OFS_W-1]}}, st.offset};
		vc      = {{(VCALC_W-VC_W){st.vcount[VC_W-1]}}, st.vcount};
		hc      = st.hold_counter;
		hold    = st.hold_flag;
		req     = 1'b0;
		done    = 1'b0;
		div     = st.tick_divider;
		end_h   = $signed(CALC_W'(st.cur_length)) + COLS_S + $signed(CALC_W'(cfg.hide_columns));
		end_v   = $signed(CALC_W'(st.cur_length)) + COLS_S;
		colstep = (st.cur_rate > cfg.fast_threshold) ? CALC_W'(1) : CALC_W'(2);
		sel_inc = {1'b0, st.frame_sel} + 1'b1;
		ld_len  = (item.frame_length > LENIN_W'(TEXT_MAX)) ? '0 : item.frame_length[LEN_W-1:0];
		ld_mode = (item.frame_mode > MODEIN_W'(MODE_UNUSED)) ? MODE_UNUSED
			: item.frame_mode[MODE_W-1:0];

		if (item.func == FUNC_LOAD) begin
			nxt.cur_length = ld_len;
			nxt.cur_mode   = ld_mode;
			nxt.cur_rate   = (item.frame_rate > cfg.rate_limit) ? '0 : item.frame_rate;
			nxt.pending    = 1'b0;
			if (ld_mode != MODE_UNUSED) begin
				nxt.hold_counter = '0;
				nxt.vcount       = '0;
				nxt.hold_flag    = 1'b0;
				case (ld_mode)
					MODE_RIGHT: nxt.offset = {{(OFS_W-LEN_W){1'b0}}, ld_len};
					MODE_UP: begin
						nxt.vcount = VC_W'(2 * SCREEN_ROWS);
						nxt.offset = OFS_W'(SCREEN_COLUMNS);
					end
					MODE_DOWN: nxt.offset = OFS_W'(SCREEN_COLUMNS);
					default:   nxt.offset = '0;
				endcase
			end
		end else if (!st.pending) begin
			if (div < DIV_MAX)
				div = div + 1'b1;
			if (div > DIV_W'(st.cur_rate)) begin
				div = '0;
				case (st.cur_mode)
					MODE_LEFT: begin
						if (!hold)
							ofs = ofs + colstep;
						if (ofs == COLS_S)
							hold = 1'b1;
						if (hold) begin
							if (hc > HOLD_W'(cfg.pause_ticks)) begin
								hold = 1'b0;
								hc   = '0;
							end else begin
								hc = hc + 1'b1;
							end
						end
						if (ofs > end_h)
							req = 1'b1;
					end
					MODE_RIGHT: begin
						if (!hold)
							ofs = ofs - colstep;
						if (ofs == COLS_S)
							hold = 1'b1;
						if (hold) begin
							if (hc > HOLD_W'(cfg.pause_ticks)) begin
								hold = 1'b0;
								hc   = '0;
							end else begin
								hc = hc + 1'b1;
							end
						end else if (ofs[CALC_W-1]) begin
							vc  = '0;
							req = 1'b1;
						end
					end
					MODE_UP: begin
						if (!vc[VCALC_W-1]) begin
							vc = vc - 1'b1;
						end else begin
							hc  = '0;
							vc  = ROWS2_S;
							ofs = ofs + COLS_S;
							if (ofs >= end_v)
								req = 1'b1;
						end
						// end of frame skips the rest of the step
						if (!req) begin
							if (hold) begin
								if (hc > HOLD_W'(cfg.pause_ticks)) begin
									hold = 1'b0;
									hc   = '0;
									done = 1'b1;
								end else begin
									hc = hc + 1'b1;
								end
								if (!done)
									vc = vc + 1'b1;
							end
							if (vc == ROWS_S)
								hold = 1'b1;
						end
					end
					MODE_DOWN: begin
						if (vc == ROWS_S)
							hold = 1'b1;
						if (vc <= ROWS2_S) begin
							vc = vc + 1'b1;
						end else begin
							vc  = '0;
							hc  = '0;
							ofs = ofs + COLS_S;
							if (ofs >= end_v)
								req = 1'b1;
						end
						if (!req && hold) begin
							if (hc > HOLD_W'(cfg.pause_ticks)) begin
								hold = 1'b0;
								hc   = '0;
								done = 1'b1;
							end else begin
								hc = hc + 1'b1;
							end
							if (!done)
								vc = vc - 1'b1;
						end
					end
					MODE_CONT: begin
						ofs = ofs + colstep;
						if (ofs > end_h)
							req = 1'b1;
					end
					default: req = 1'b1;
				endcase
			end
			nxt.tick_divider = div;
			nxt.offset       = ofs[OFS_W-1:0];
			nxt.vcount       = vc[VC_W-1:0];
			nxt.hold_flag    = hold;
			nxt.hold_counter = hc;
			if (req) begin
				nxt.frame_sel = (sel_inc >= (FRAME_W+1)'(FRAME_COUNT)) ? '0
					: sel_inc[FRAME_W-1:0];
				nxt.pending   = 1'b1;
			end
		end
	end

endmodule

// ----- rtl/led_marquee_scroll_sequencer_core.sv -----
// top level of the marquee scroll sequencer: input register, state, result register
// depends on lmss_pkg and lmss_step
//
// Scroll sequencer for a scrolling LED message board. Each input transfer is either a
// millisecond tick (func = 0) or the settings of the frame named by frame_number
// (func = 1); every input transfer gives exactly one result transfer carrying the
// column offset, vertical count, pause flag, frame number and load request as they stand
// after that item. After reset a load is pending in the state and frame 0 is awaited; ticks are
// ignored while a load is awaited. One item is taken per clock cycle while out_ready stays
// high, and each result passes from the input register through the step logic into the
// result register. While a result waits for out_ready the input register still takes one
// more item. Registers are written through cfg_write, cfg_index and cfg_data and take effect
// at once; write them only while no item is in flight.
module led_marquee_scroll_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_write,
	input  logic [lmss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lmss_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [lmss_pkg::RATE_W-1:0]         frame_rate,
	input  logic [lmss_pkg::MODEIN_W-1:0]       frame_mode,
	input  logic [lmss_pkg::LENIN_W-1:0]        frame_length,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lmss_pkg::OFS_W-1:0]   column_offset,
	output logic signed [lmss_pkg::VC_W-1:0]    vertical_count,
	output logic                                paused,
	output logic [lmss_pkg::FRAME_W-1:0]        frame_number,
	output logic                                load_request
);
	import lmss_pkg::*;

	lmss_cfg_t   cfg_q;
	lmss_state_t state_q;
	lmss_state_t state_nxt;
	lmss_item_t  item_s1;
	logic        valid_s1;
	logic        advance;

	logic                    out_valid_q;
	logic signed [OFS_W-1:0] offset_s2;
	logic signed [VC_W-1:0]  vcount_s2;
	logic                    hold_s2;
	logic [FRAME_W-1:0]      frame_s2;
	logic                    pending_s2;

	// the held item moves on when the result register is empty or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;

	// configuration registers, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_threshold <= COLCFG_W'(5);
			cfg_q.hide_columns   <= COLCFG_W'(8);
			cfg_q.rate_limit     <= RATE_W'(100);
			cfg_q.pause_ticks    <= PAUSE_W'(50);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FAST_THRESHOLD: cfg_q.fast_threshold <= cfg_data[COLCFG_W-1:0];
				REG_HIDE_COLUMNS:   cfg_q.hide_columns   <= cfg_data[COLCFG_W-1:0];
				REG_RATE_LIMIT:     cfg_q.rate_limit     <= cfg_data[RATE_W-1:0];
				REG_PAUSE_TICKS:    cfg_q.pause_ticks    <= cfg_data[PAUSE_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.func         <= func;
			item_s1.frame_rate   <= frame_rate;
			item_s1.frame_mode   <= frame_mode;
			item_s1.frame_length <= frame_length;
		end
	end

	lmss_step u_step (
		.cfg  (cfg_q),
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt)
	);

	// sequencer state, updated once per item as it moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.tick_divider <= '0;
			state_q.offset       <= '0;
			state_q.vcount       <= '0;
			state_q.hold_flag    <= 1'b0;
			state_q.hold_counter <= '0;
			state_q.frame_sel    <= '0;
			state_q.cur_rate     <= '0;
			state_q.cur_mode     <= MODE_UNUSED;
			state_q.cur_length   <= '0;
			state_q.pending      <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register: payload is the state right after the item
	always_ff @(posedge clk) begin
		if (advance) begin
			offset_s2  <= state_nxt.offset;
			vcount_s2  <= state_nxt.vcount;
			hold_s2    <= state_nxt.hold_flag;
			frame_s2   <= state_nxt.frame_sel;
			pending_s2 <= state_nxt.pending;
		end
	end

	assign out_valid      = out_valid_q;
	assign column_offset  = offset_s2;
	assign vertical_count = vcount_s2;
	assign paused         = hold_s2;
	assign frame_number   = frame_s2;
	assign load_request   = pending_s2;

endmodule

// ----- rtl/lmss_checker.sv -----
// port-level checks on the marquee scroll sequencer, bound to its top level
// depends on lmss_pkg and assert_macros.svh
`include "assert_macros.svh"

module lmss_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [lmss_pkg::OFS_W-1:0]   column_offset,
	input logic signed [lmss_pkg::VC_W-1:0]    vertical_count,
	input logic                                paused,
	input logic [lmss_pkg::FRAME_W-1:0]        frame_number,
	input logic                                load_request
);
	import lmss_pkg::*;

	logic stalled;

	// a result is showing but the receiver holds it off
	assign stalled = out_valid && !out_ready;

	// an accepted item is followed by a result showing once it has moved through the input register
	`ASSERT_IMPL(a_in_to_out, clk, arst_n, in_valid && in_ready, ##2 out_valid)

	// input side only backs up when a result is stalled
	`ASSERT_IMPL(a_ready_low_stall, clk, arst_n, !in_ready, stalled)

	// a stalled result holds its position fields
	`ASSERT_NEXT(a_out_hold_pos, clk, arst_n, stalled, out_valid && $stable({column_offset, vertical_count}))

	// a stalled result holds its flags and frame number
	`ASSERT_NEXT(a_out_hold_flags, clk, arst_n, stalled, $stable({paused, frame_number, load_request}))

endmodule

bind led_marquee_scroll_sequencer_core lmss_checker u_lmss_checker (.*);

// ----- tb/led_marquee_scroll_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for led_marquee_scroll_sequencer_core
// depends on lmss_pkg and the core; a directed table, then random phases with idling
module led_marquee_scroll_sequencer_core_tb;
	import lmss_pkg::*;

	// one result transfer as the board shows it
	typedef struct packed {
		logic signed [OFS_W-1:0] ofs;
		logic signed [VC_W-1:0]  vpos;
		logic                    held;
		logic [FRAME_W-1:0]      frame;
		logic                    awaiting;
	} marquee_view_t;

	// one row of the directed table; known rows carry a hand-written view
	typedef struct packed {
		logic                func;
		logic [RATE_W-1:0]   rate;
		logic [MODEIN_W-1:0] mode;
		logic [LENIN_W-1:0]  len;
		logic                known;
		marquee_view_t       view;
	} script_row_t;

	// scroll state as the predictor tracks it; positions kept as plain ints
	typedef struct {
		logic [DIV_W-1:0]   div;
		int                 ofs;
		int                 vpos;
		logic               held;
		logic [HOLD_W-1:0]  hold_cnt;
		logic [FRAME_W-1:0] frame;
		logic [RATE_W-1:0]  rate;
		logic [MODE_W-1:0]  mode;
		logic [LEN_W-1:0]   len;
		logic               awaiting;
	} board_t;

	localparam int DRAIN_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [RATE_W-1:0] frame_rate;
	logic [MODEIN_W-1:0] frame_mode;
	logic [LENIN_W-1:0] frame_length;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [OFS_W-1:0] column_offset;
	logic signed [VC_W-1:0] vertical_count;
	logic paused;
	logic [FRAME_W-1:0] frame_number;
	logic load_request;

	// predictor state and the register copy it reads
	board_t board;
	lmss_cfg_t cfg_now;
	marquee_view_t expected_views[$];
	script_row_t script[$];

	// idle percentages of the two sides, changed per phase
	int idle_in = 0;
	int idle_out = 0;

	int failures = 0;
	int results_seen = 0;
	int stranded = 0;
	int loads_sent = 0;
	int ticks_sent = 0;
	int scroll_steps = 0;
	int frame_ends = 0;
	int holds_done = 0;

	led_marquee_scroll_sequencer_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.frame_rate     (frame_rate),
		.frame_mode     (frame_mode),
		.frame_length   (frame_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.column_offset  (column_offset),
		.vertical_count (vertical_count),
		.paused         (paused),
		.frame_number   (frame_number),
		.load_request   (load_request)
	);

	always #5 clk = ~clk;

	// receiver back-pressure, one fresh draw per cycle
	always @(posedge clk) begin
		out_ready <= (idle_out == 0) || ($urandom_range(99) >= idle_out);
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------

	// frame finished: move to the next one, wrapping, and ask for its settings
	function automatic void request_frame();
		board.frame = (int'(board.frame) + 1 >= FRAME_COUNT) ? '0 : board.frame + 1'b1;
		board.awaiting = 1'b1;
		frame_ends++;
	endfunction

	// one count of the centre hold; true when the hold has just run out
	function automatic bit hold_count_step();
		logic [HOLD_W-1:0] prior;
		prior = board.hold_cnt;
		board.hold_cnt = prior + 1'b1;
		if (prior > cfg_now.pause_ticks) begin
			board.held = 1'b0;
			board.hold_cnt = '0;
			holds_done++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// slow frames creep one column, fast ones jump two
	function automatic int stride();
		return (board.rate > cfg_now.fast_threshold) ? 1 : 2;
	endfunction

	function automatic void scroll();
		int end_h;
		int end_v;
		end_h = int'(board.len) + SCREEN_COLUMNS + int'(cfg_now.hide_columns);
		end_v = int'(board.len) + SCREEN_COLUMNS;
		scroll_steps++;
		case (board.mode)
			MODE_LEFT: begin
				if (!board.held)
					board.ofs += stride();
				if (board.ofs == SCREEN_COLUMNS)
					board.held = 1'b1;
				if (board.held)
					void'(hold_count_step());
				if (board.ofs > end_h)
					request_frame();
			end
			MODE_RIGHT: begin
				if (!board.held)
					board.ofs -= stride();
				if (board.ofs == SCREEN_COLUMNS)
					board.held = 1'b1;
				if (board.held) begin
					void'(hold_count_step());
				end else if (board.ofs < 0) begin
					board.vpos = 0;
					request_frame();
				end
			end
			MODE_UP: begin
				if (board.vpos >= 0) begin
					board.vpos--;
				end else begin
					// row done: next block of columns, or end of frame
					board.hold_cnt = '0;
					board.vpos = 2 * SCREEN_ROWS;
					board.ofs += SCREEN_COLUMNS;
					if (board.ofs >= end_v) begin
						request_frame();
						return;
					end
				end
				if (board.held) begin
					if (!hold_count_step())
						board.vpos++;
				end
				if (board.vpos == SCREEN_ROWS)
					board.held = 1'b1;
			end
			MODE_DOWN: begin
				if (board.vpos == SCREEN_ROWS)
					board.held = 1'b1;
				if (board.vpos <= 2 * SCREEN_ROWS) begin
					board.vpos++;
				end else begin
					board.vpos = 0;
					board.hold_cnt = '0;
					board.ofs += SCREEN_COLUMNS;
					if (board.ofs >= end_v) begin
						request_frame();
						return;
					end
				end
				if (board.held) begin
					if (!hold_count_step())
						board.vpos--;
				end
			end
			MODE_CONT: begin
				board.ofs += stride();
				if (board.ofs > end_h)
					request_frame();
			end
			default: begin
				request_frame();
			end
		endcase
	endfunction

	// applies one accepted item and returns the view it should produce
	function automatic marquee_view_t advance_board(input logic f,
			input logic [RATE_W-1:0] r, input logic [MODEIN_W-1:0] m,
			input logic [LENIN_W-1:0] l);
		marquee_view_t view;
		if (f == FUNC_LOAD) begin
			// sanitize, then place the message at the mode's start
			board.len = (l > TEXT_MAX) ? '0 : LEN_W'(l);
			board.mode = (m > MODE_UNUSED) ? MODE_UNUSED : MODE_W'(m);
			board.rate = (r > cfg_now.rate_limit) ? '0 : r;
			board.awaiting = 1'b0;
			if (board.mode != MODE_UNUSED) begin
				board.hold_cnt = '0;
				board.vpos = 0;
				board.held = 1'b0;
				case (board.mode)
					MODE_RIGHT: board.ofs = int'(board.len);
					MODE_UP: begin
						board.vpos = 2 * SCREEN_ROWS;
						board.ofs = SCREEN_COLUMNS;
					end
					MODE_DOWN: board.ofs = SCREEN_COLUMNS;
					default: board.ofs = 0;
				endcase
			end
		end else if (!board.awaiting) begin
			if (board.div < DIV_MAX)
				board.div++;
			if (board.div > board.rate) begin
				scroll();
				board.div = '0;
			end
		end
		view.ofs = OFS_W'(board.ofs);
		view.vpos = VC_W'(board.vpos);
		view.held = board.held;
		view.frame = board.frame;
		view.awaiting = board.awaiting;
		return view;
	endfunction

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	function automatic void plan(input logic f, input int r, input int m, input int l,
			input logic known, input int ofs, input int vpos, input int held,
			input int frame, input int req);
		script_row_t row;
		row.func = f;
		row.rate = RATE_W'(r);
		row.mode = MODEIN_W'(m);
		row.len = LENIN_W'(l);
		row.known = known;
		row.view.ofs = OFS_W'(ofs);
		row.view.vpos = VC_W'(vpos);
		row.view.held = held[0];
		row.view.frame = FRAME_W'(frame);
		row.view.awaiting = req[0];
		script.push_back(row);
	endfunction

	// one input transfer: optional sender idling, then hold valid until taken
	task automatic offer(input logic f, input logic [RATE_W-1:0] r,
			input logic [MODEIN_W-1:0] m, input logic [LENIN_W-1:0] l,
			input logic known, input marquee_view_t known_view);
		marquee_view_t view;
		while (idle_in != 0 && $urandom_range(99) < idle_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		frame_rate <= r;
		frame_mode <= m;
		frame_length <= l;
		do
			@(posedge clk);
		while (!in_ready);
		view = advance_board(f, r, m, l);
		if (f == FUNC_LOAD)
			loads_sent++;
		else
			ticks_sent++;
		expected_views.push_back(known ? known_view : view);
	endtask

	// tick with a junk payload, which the block must not look at
	task automatic offer_tick();
		offer(FUNC_TICK, RATE_W'($urandom), MODEIN_W'($urandom), LENIN_W'($urandom),
			1'b0, '0);
	endtask

	// frame settings weighted toward quick frames that reach their end
	task automatic offer_random_load();
		int pick;
		logic [RATE_W-1:0] r;
		logic [MODEIN_W-1:0] m;
		logic [LENIN_W-1:0] l;
		pick = $urandom_range(99);
		if (pick < 60)
			r = '0;
		else if (pick < 85)
			r = RATE_W'($urandom_range(3, 1));
		else if (pick < 95)
			r = RATE_W'($urandom_range(12, 4));
		else
			r = RATE_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 85)
			m = MODEIN_W'($urandom_range(MODE_CONT, MODE_LEFT));
		else if (pick < 92)
			m = MODEIN_W'(MODE_UNUSED);
		else
			m = MODEIN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 72)
			l = LENIN_W'($urandom_range(40, 0));
		else if (pick < 90)
			l = LENIN_W'($urandom_range(160, 41));
		else if (pick < 93)
			l = LENIN_W'($urandom_range(TEXT_MAX, TEXT_MAX - 24));
		else
			l = LENIN_W'($urandom);
		offer(FUNC_LOAD, r, m, l, 1'b0, '0);
	endtask

	// drop valid and let every result drain, up to the drain limit, then wait out a margin
	task automatic settle();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_views.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	// writes all four registers back to back; only called with the block idle
	task automatic program_regs(input logic [CFG_DATA_W-1:0] fast,
			input logic [CFG_DATA_W-1:0] hide, input logic [CFG_DATA_W-1:0] limit,
			input logic [CFG_DATA_W-1:0] pause);
		cfg_write <= 1'b1;
		cfg_index <= REG_FAST_THRESHOLD;
		cfg_data <= fast;
		@(posedge clk);
		cfg_index <= REG_HIDE_COLUMNS;
		cfg_data <= hide;
		@(posedge clk);
		cfg_index <= REG_RATE_LIMIT;
		cfg_data <= limit;
		@(posedge clk);
		cfg_index <= REG_PAUSE_TICKS;
		cfg_data <= pause;
		@(posedge clk);
		cfg_write <= 1'b0;
		// the block masks each value to its register width
		cfg_now.fast_threshold = fast[COLCFG_W-1:0];
		cfg_now.hide_columns = hide[COLCFG_W-1:0];
		cfg_now.rate_limit = limit[RATE_W-1:0];
		cfg_now.pause_ticks = pause[PAUSE_W-1:0];
	endtask

	// ---------------------------------------------------------------
	// result checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin : check_results
		marquee_view_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_views.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result transfer %0d with nothing expected: ofs %0d vpos %0d",
						results_seen, column_offset, vertical_count);
			end else begin
				want = expected_views.pop_front();
				if (column_offset !== want.ofs || vertical_count !== want.vpos ||
						paused !== want.held || frame_number !== want.frame ||
						load_request !== want.awaiting) begin
					failures++;
					if (failures <= 10) begin
						$display("result %0d mismatch: exp ofs %0d vpos %0d paused %0b frame %0d req %0b",
							results_seen, want.ofs, want.vpos, want.held, want.frame,
							want.awaiting);
						$display("                      got ofs %0d vpos %0d paused %0b frame %0d req %0b",
							column_offset, vertical_count, paused, frame_number, load_request);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		int counted;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_FAST_THRESHOLD;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_TICK;
		frame_rate = '0;
		frame_mode = '0;
		frame_length = '0;

		// predictor at its reset point: frame 0 awaited, unused mode
		cfg_now.fast_threshold = 8'd5;
		cfg_now.hide_columns = 8'd8;
		cfg_now.rate_limit = 8'd100;
		cfg_now.pause_ticks = 10'd50;
		board.div = '0;
		board.ofs = 0;
		board.vpos = 0;
		board.held = 1'b0;
		board.hold_cnt = '0;
		board.frame = '0;
		board.rate = '0;
		board.mode = MODE_UNUSED;
		board.len = '0;
		board.awaiting = 1'b1;

		// directed table, reset register values
		// tick before any load is ignored
		plan(FUNC_TICK, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1);
		plan(FUNC_LOAD, 0, MODE_LEFT, 0, 1'b1, 0, 0, 0, 0, 0);
		// rate 0 is at or below the threshold, so two columns
		plan(FUNC_TICK, 0, 0, 0, 1'b1, 2, 0, 0, 0, 0);
		// everything out of range: rate to 0, mode to unused, length to 0; position kept
		plan(FUNC_LOAD, 255, 255, 65535, 1'b1, 2, 0, 0, 0, 0);
		// unused frame ends at its first step
		plan(FUNC_TICK, 0, 0, 0, 1'b1, 2, 0, 0, 1, 1);
		plan(FUNC_TICK, 255, 255, 65535, 1'b1, 2, 0, 0, 1, 1);
		// rate just above the rate limit is dropped to 0
		plan(FUNC_LOAD, 101, MODE_RIGHT, 1, 1'b1, 1, 0, 0, 1, 0);
		// right scroll runs below zero and ends the frame
		plan(FUNC_TICK, 0, 0, 0, 1'b1, -1, 0, 0, 2, 1);
		// rate at the rate limit and the longest legal message are kept
		plan(FUNC_LOAD, 100, MODE_UP, TEXT_MAX, 1'b1, SCREEN_COLUMNS, 2 * SCREEN_ROWS, 0, 2, 0);
		plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
		// load while nothing is awaited still takes effect
		plan(FUNC_LOAD, 0, MODE_DOWN, 0, 1'b0, 0, 0, 0, 0, 0);
		plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
		plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
		// length one past the text store counts as empty
		plan(FUNC_LOAD, 0, MODE_CONT, TEXT_MAX + 1, 1'b0, 0, 0, 0, 0, 0);
		plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
		// first mode code past unused
		plan(FUNC_LOAD, 0, int'(MODE_UNUSED) + 1, 5, 1'b0, 0, 0, 0, 0, 0);
		plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);
		// rate above the threshold: one column every seven ticks
		plan(FUNC_LOAD, 6, MODE_LEFT, 16, 1'b0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 7; i++)
			plan(FUNC_TICK, 0, 0, 0, 1'b0, 0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_in = 26;
		idle_out = 76;
		foreach (script[i])
			offer(script[i].func, script[i].rate, script[i].mode, script[i].len,
				script[i].known, script[i].view);

		// random phases: two per idling pattern, each with its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph / 2)
				0: begin
					idle_in = 26;
					idle_out = 76;
				end
				1: begin
					idle_in = 76;
					idle_out = 26;
				end
				default: begin
					idle_in = 0;
					idle_out = 0;
				end
			endcase
			case (ph)
				0: program_regs(10'd5, 10'd8, 10'd100, 10'd2);
				// low extremes: every rate drops to 0, holds release at their second count
				1: program_regs('0, '0, '0, '0);
				// high extremes, with the unused upper data bits set as well
				3: program_regs('1, '1, '1, '1);
				// full data range, masked by the block
				4: program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
					CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(8, 0)));
				default: program_regs(CFG_DATA_W'($urandom_range(10, 0)),
					CFG_DATA_W'($urandom_range(16, 0)), CFG_DATA_W'($urandom_range(255, 0)),
					CFG_DATA_W'($urandom_range(6, 0)));
			endcase

			// mostly well-formed frames: a load when asked, then ticks;
			// some ignored ticks while waiting and rare loads mid-frame
			counted = 0;
			while (counted < 150) begin
				if (board.awaiting) begin
					if ($urandom_range(99) < 8) begin
						offer_tick();
					end else begin
						offer_random_load();
						counted++;
					end
				end else if ($urandom_range(99) == 0) begin
					offer_random_load();
					counted++;
				end else begin
					offer_tick();
					counted++;
				end
			end
		end

		settle();
		stranded = expected_views.size();
		if (stranded != 0)
			$display("%0d expected results never arrived", stranded);
		$display("checked %0d result transfers from %0d loads and %0d ticks over six register settings",
			results_seen, loads_sent, ticks_sent);
		$display("predictor ran %0d scroll steps, %0d frame ends and %0d released holds",
			scroll_steps, frame_ends, holds_done);
		if (failures == 0 && stranded == 0) begin
			$display("led_marquee_scroll_sequencer_core verification clean");
		end else begin
			$display("led_marquee_scroll_sequencer_core verification failed");
		end
		$finish;
	end

	// watchdog against a stuck handshake
	initial begin
		#2_000_000;
		$display("timeout waiting on a transfer");
		$display("led_marquee_scroll_sequencer_core verification failed");
		$finish;
	end

endmodule
